[sv/alee_pkg.sv]
`timescale 1ns / 1ps

package alee_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 7;

  // command codes as they arrive on the input channel
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_DEDUPE = 3'd5,
    CMD_DUMP   = 3'd6
  } cmd_e;

  // decoded operation handed to the execution side
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_UPDATE,
    OP_INSERT,
    OP_DELETE,
    OP_DEDUPE,
    OP_DUMP,
    OP_BAD
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DD_READ,
    ST_DD_CMP,
    ST_STREAM
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [POS_W-1:0]         word_index;
    logic [LEN_W-1:0]         length;
    logic                     word_valid;
    logic                     status;
    logic                     last;
  } res_t;

  typedef struct packed {
    op_e                      op;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } job_t;

  // queue head as seen by the execution side
  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

endpackage

[sv/alee_stream_if.sv]
`timescale 1ns / 1ps

interface alee_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

[sv/alee_front.sv]
`timescale 1ns / 1ps

module alee_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  alee_stream_if.snk          cmd_i,
  output alee_pkg::job_head_t head_o,
  input  logic                pop_i
);

  alee_pkg::job_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  alee_pkg::job_t job_in;
  logic           push, pop;

  // classify the incoming command
  always_comb begin
    job_in.position = cmd_i.data.position;
    job_in.value    = cmd_i.data.value;
    case (alee_pkg::cmd_e'(cmd_i.data.command))
      alee_pkg::CMD_CLEAR:  job_in.op = alee_pkg::OP_CLEAR;
      alee_pkg::CMD_APPEND: job_in.op = alee_pkg::OP_APPEND;
      alee_pkg::CMD_UPDATE: job_in.op = alee_pkg::OP_UPDATE;
      alee_pkg::CMD_INSERT: job_in.op = alee_pkg::OP_INSERT;
      alee_pkg::CMD_DELETE: job_in.op = alee_pkg::OP_DELETE;
      alee_pkg::CMD_DEDUPE: job_in.op = alee_pkg::OP_DEDUPE;
      alee_pkg::CMD_DUMP:   job_in.op = alee_pkg::OP_DUMP;
      default:              job_in.op = alee_pkg::OP_BAD;
    endcase
  end

  assign cmd_i.ready = (cnt_q != 2'd2);
  assign push        = cmd_i.valid && cmd_i.ready;
  assign pop         = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.job   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

[sv/alee_back.sv]
`timescale 1ns / 1ps

module alee_back #(
  parameter int CAPACITY = alee_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  alee_pkg::job_head_t head_i,
  output logic                pop_o,
  alee_stream_if.src          res_o
);

  localparam int LenW  = $clog2(CAPACITY + 1);
  localparam int IdxW  = $clog2(CAPACITY);
  localparam int PosW  = alee_pkg::POS_W;
  localparam int OutLW = alee_pkg::LEN_W;
  localparam int WordW = alee_pkg::WORD_W;

  alee_pkg::state_e  state_q, state_d;
  logic [WordW-1:0]  list_q [CAPACITY];
  logic [WordW-1:0]  list_d [CAPACITY];
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   idx_q, idx_d;
  logic [LenW-1:0]   rd_q, rd_d;
  logic [LenW-1:0]   wr_q, wr_d;
  logic [WordW-1:0]  cand_q, cand_d;
  logic              status_q, status_d;
  alee_pkg::res_t    res_q, res_d;
  logic              res_valid_q, res_valid_d;
  logic [OutLW-1:0]  pos_ext, len_ext;
  logic [IdxW-1:0]   pos_idx;
  logic              full;
  logic              match;
  logic              last_word;

  assign pos_ext   = OutLW'(head_i.job.position);
  assign len_ext   = OutLW'(len_q);
  assign pos_idx   = IdxW'(head_i.job.position);
  assign full      = (len_q == LenW'(CAPACITY));
  assign last_word = (LenW'(idx_q + 1'b1) == len_q);

  // candidate against every word already kept
  always_comb begin
    match = 1'b0;
    for (int k = 0; k < CAPACITY; k++) begin
      if ((LenW'(k) < wr_q) && (list_q[k] == cand_q)) begin
        match = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    list_d      = list_q;
    len_d       = len_q;
    idx_d       = idx_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    cand_d      = cand_q;
    status_d    = status_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_o.ready;
    pop_o       = 1'b0;

    case (state_q)
      alee_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          status_d = 1'b0;
          idx_d    = '0;
          state_d  = alee_pkg::ST_STREAM;
          case (head_i.job.op)
            alee_pkg::OP_CLEAR: begin
              len_d = '0;
            end
            alee_pkg::OP_APPEND: begin
              if (full) begin
                status_d = 1'b1;
              end else begin
                list_d[len_q[IdxW-1:0]] = head_i.job.value;
                len_d = len_q + 1'b1;
              end
            end
            alee_pkg::OP_UPDATE: begin
              if (pos_ext >= len_ext) begin
                status_d = 1'b1;
              end else begin
                list_d[pos_idx] = head_i.job.value;
              end
            end
            alee_pkg::OP_INSERT: begin
              if (full || (pos_ext > len_ext)) begin
                status_d = 1'b1;
              end else begin
                // later words move up by one
                for (int k = 1; k < CAPACITY; k++) begin
                  if ((OutLW'(k) > pos_ext) && (LenW'(k) <= len_q)) begin
                    list_d[k] = list_q[k-1];
                  end
                end
                list_d[pos_idx] = head_i.job.value;
                len_d = len_q + 1'b1;
              end
            end
            alee_pkg::OP_DELETE: begin
              if (pos_ext >= len_ext) begin
                status_d = 1'b1;
              end else begin
                for (int k = 0; k < CAPACITY - 1; k++) begin
                  if ((OutLW'(k) >= pos_ext) && (LenW'(k + 1) < len_q)) begin
                    list_d[k] = list_q[k+1];
                  end
                end
                len_d = len_q - 1'b1;
              end
            end
            alee_pkg::OP_DEDUPE: begin
              rd_d    = '0;
              wr_d    = '0;
              state_d = alee_pkg::ST_DD_READ;
            end
            alee_pkg::OP_DUMP: begin
              status_d = 1'b0;
            end
            default: begin
              status_d = 1'b1;
            end
          endcase
        end
      end

      alee_pkg::ST_DD_READ: begin
        if (rd_q == len_q) begin
          len_d   = wr_q;
          state_d = alee_pkg::ST_STREAM;
        end else begin
          cand_d  = list_q[rd_q[IdxW-1:0]];
          state_d = alee_pkg::ST_DD_CMP;
        end
      end

      alee_pkg::ST_DD_CMP: begin
        // compaction in place: the write slot never passes the read slot
        if (!match) begin
          list_d[wr_q[IdxW-1:0]] = cand_q;
          wr_d = wr_q + 1'b1;
        end
        rd_d    = rd_q + 1'b1;
        state_d = alee_pkg::ST_DD_READ;
      end

      alee_pkg::ST_STREAM: begin
        if (!res_valid_q || res_o.ready) begin
          res_valid_d  = 1'b1;
          res_d.status = status_q;
          if (len_q == '0) begin
            res_d.word       = '0;
            res_d.word_index = '0;
            res_d.length     = '0;
            res_d.word_valid = 1'b0;
            res_d.last       = 1'b1;
            state_d          = alee_pkg::ST_IDLE;
          end else begin
            res_d.word       = list_q[idx_q[IdxW-1:0]];
            res_d.word_index = PosW'(idx_q);
            res_d.length     = len_ext;
            res_d.word_valid = 1'b1;
            res_d.last       = last_word;
            idx_d            = idx_q + 1'b1;
            if (last_word) begin
              state_d = alee_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = alee_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alee_pkg::ST_IDLE;
      len_q       <= '0;
      idx_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      status_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      status_q    <= status_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
    cand_q <= cand_d;
    res_q  <= res_d;
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(CAPACITY))
    else $error("list length above capacity");

  a_dd_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == alee_pkg::ST_DD_READ || state_q == alee_pkg::ST_DD_CMP)
      |-> (wr_q <= rd_q && rd_q <= len_q))
    else $error("dedupe write slot passed read slot");

  a_stream_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == alee_pkg::ST_STREAM && len_q != '0) |-> idx_q < len_q)
    else $error("stream index past list end");

  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.word_valid) |-> (res_q.last && res_q.length == '0))
    else $error("empty list result malformed");
`endif

endmodule

[sv/array_list_edit_engine.sv]
`timescale 1ns / 1ps

// array list edit engine: an ordered list of signed 32-bit words
// cmd_i takes one command word (command, position, value) per valid/ready
// handshake into a two-deep queue; ready drops only when that queue is full
// res_o returns the whole list after each command, one word per handshake,
// word_index counting up from 0 and last set on the final word; an empty
// list gives a single word with word_valid low
// status is set on every word of a rejected command (bad index, full list,
// unknown code); a rejected command changes nothing
// flow: the edit is applied as the command leaves the queue (insert and delete
// shift all words at once), then one word a cycle leaves the output register
// while the receiver is ready; dedupe first compacts the list in place, with a
// read state and a compare state per stored word, and then streams it
// a stalled receiver holds the output register and the streaming stops;
// commands keep queuing until the queue is full
// reset empties the list and the queue; no clearing pass is needed

module array_list_edit_engine #(
  parameter int CAPACITY = alee_pkg::CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  alee_stream_if.snk cmd_i,
  alee_stream_if.src res_o
);

  alee_pkg::job_head_t head;
  logic                pop;

  alee_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .head_o (head),
    .pop_i  (pop)
  );

  alee_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

[verif/array_list_edit_engine_checker.sv]
`timescale 1ns / 1ps

module array_list_edit_engine_checker #(
  parameter int CAPACITY = alee_pkg::CAPACITY_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  logic            cmd_ready_i,
  input  alee_pkg::cmd_t  cmd_data_i,
  input  logic            res_valid_i,
  input  logic            res_ready_i,
  input  alee_pkg::res_t  res_data_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o,
  output int unsigned     list_len_o
);

  logic [alee_pkg::WORD_W-1:0] held_words [CAPACITY];
  int unsigned                 held_len = 0;
  alee_pkg::res_t              due_words [$];
  int unsigned                 mismatches = 0;

  assign fail_count_o = mismatches;
  assign list_len_o   = held_len;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // edit the shadow list, then queue the full listing that must come back
  task automatic apply_edit(input alee_pkg::cmd_t c);
    logic           rejected;
    int unsigned    p;
    int unsigned    keep;
    bit             dup;
    alee_pkg::res_t r;
    rejected = 1'b0;
    p = c.position;
    case (alee_pkg::cmd_e'(c.command))
      alee_pkg::CMD_CLEAR: held_len = 0;
      alee_pkg::CMD_APPEND: begin
        if (held_len >= CAPACITY) rejected = 1'b1;
        else begin
          held_words[held_len] = c.value;
          held_len++;
        end
      end
      alee_pkg::CMD_UPDATE: begin
        if (p >= held_len) rejected = 1'b1;
        else held_words[p] = c.value;
      end
      alee_pkg::CMD_INSERT: begin
        if (held_len >= CAPACITY || p > held_len) rejected = 1'b1;
        else begin
          for (int i = held_len; i > p; i--) held_words[i] = held_words[i-1];
          held_words[p] = c.value;
          held_len++;
        end
      end
      alee_pkg::CMD_DELETE: begin
        if (p >= held_len) rejected = 1'b1;
        else begin
          for (int i = p; i + 1 < held_len; i++) held_words[i] = held_words[i+1];
          held_len--;
        end
      end
      alee_pkg::CMD_DEDUPE: begin
        // keep first occurrence of each value, full 32-bit compare
        keep = 0;
        for (int i = 0; i < held_len; i++) begin
          dup = 1'b0;
          for (int j = 0; j < keep; j++) begin
            if (held_words[j] == held_words[i]) dup = 1'b1;
          end
          if (!dup) begin
            held_words[keep] = held_words[i];
            keep++;
          end
        end
        held_len = keep;
      end
      alee_pkg::CMD_DUMP: ;
      default: rejected = 1'b1;
    endcase

    if (held_len == 0) begin
      r = '0;
      r.status = rejected;
      r.last   = 1'b1;
      due_words.push_back(r);
    end else begin
      for (int i = 0; i < held_len; i++) begin
        r.word       = held_words[i];
        r.word_index = i[alee_pkg::POS_W-1:0];
        r.length     = held_len[alee_pkg::LEN_W-1:0];
        r.word_valid = 1'b1;
        r.status     = rejected;
        r.last       = (i + 1 == held_len);
        due_words.push_back(r);
      end
    end
  endtask

  task automatic check_word(input alee_pkg::res_t got);
    alee_pkg::res_t want;
    if (due_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word index %0d value %h",
                                got.word_index, got.word));
      return;
    end
    want = due_words.pop_front();
    if (got.word !== want.word)
      report_mismatch($sformatf("index %0d word got %h want %h",
                                want.word_index, got.word, want.word));
    if (got.word_index !== want.word_index)
      report_mismatch($sformatf("word_index got %0d want %0d",
                                got.word_index, want.word_index));
    if (got.length !== want.length)
      report_mismatch($sformatf("index %0d length got %0d want %0d",
                                want.word_index, got.length, want.length));
    if (got.word_valid !== want.word_valid)
      report_mismatch($sformatf("index %0d word_valid got %b want %b",
                                want.word_index, got.word_valid, want.word_valid));
    if (got.status !== want.status)
      report_mismatch($sformatf("index %0d status got %b want %b",
                                want.word_index, got.status, want.status));
    if (got.last !== want.last)
      report_mismatch($sformatf("index %0d last got %b want %b",
                                want.word_index, got.last, want.last));
  endtask

  // results first: a word leaving in the same cycle belongs to an older command
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_i && res_ready_i) check_word(res_data_i);
      if (cmd_valid_i && cmd_ready_i) apply_edit(cmd_data_i);
    end
    pending_o = due_words.size();
  end

endmodule

[verif/array_list_edit_engine_tb.sv]
`timescale 1ns / 1ps

module array_list_edit_engine_tb;

  localparam int CAPACITY = alee_pkg::CAPACITY_DEF;
  localparam int CODE_W = alee_pkg::CMD_W;
  localparam logic [CODE_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 105;

  logic clk_i = 1'b0;
  logic rst_ni;

  alee_stream_if #(.T(alee_pkg::cmd_t)) cmd_if ();
  alee_stream_if #(.T(alee_pkg::res_t)) res_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned list_len;

  int unsigned len_est = 0;
  int unsigned random_sent = 0;
  bit          calm = 1'b0;

  always #5 clk_i = ~clk_i;

  array_list_edit_engine #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  array_list_edit_engine_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_if.valid),
    .cmd_ready_i (cmd_if.ready),
    .cmd_data_i  (cmd_if.data),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_data_i  (res_if.data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .list_len_o  (list_len)
  );

  function automatic logic [alee_pkg::WORD_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return $urandom_range(0, 3);  // small pool feeds dedupe
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input logic [CODE_W-1:0] code, input int unsigned pos,
                          input logic [alee_pkg::WORD_W-1:0] val);
    int unsigned    gap;
    alee_pkg::cmd_t item;
    item.command  = code;
    item.position = pos[alee_pkg::POS_W-1:0];
    item.value    = val;
    if ($urandom_range(0, 11) == 0) calm = !calm;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= item;
    do @(posedge clk_i); while (!cmd_if.ready);
    random_sent++;
    case (code)
      alee_pkg::CMD_CLEAR: len_est = 0;
      alee_pkg::CMD_APPEND: if (len_est < CAPACITY) len_est++;
      alee_pkg::CMD_INSERT: if (len_est < CAPACITY && pos <= len_est) len_est++;
      alee_pkg::CMD_DELETE: if (pos < len_est) len_est--;
      alee_pkg::CMD_DEDUPE: begin
        // new length is data dependent, read it back from the checker
        cmd_if.valid <= 1'b0;
        @(negedge clk_i);
        len_est = list_len;
        @(posedge clk_i);
      end
      default: ;
    endcase
  endtask

  // receiver: random stall before each word
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  initial begin
    #5_000_000;
    $display("array_list_edit_engine test failed");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned op;
    bit          bad;
    bit          first;
    rst_ni       <= 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, edges of each command, extreme words
    send_cmd(alee_pkg::CMD_DUMP,   0, 32'h0);
    send_cmd(alee_pkg::CMD_DELETE, 0, 32'h0);
    send_cmd(alee_pkg::CMD_UPDATE, 0, 32'h1);
    send_cmd(alee_pkg::CMD_INSERT, 1, 32'h2);
    send_cmd(alee_pkg::CMD_INSERT, 0, 32'h7fff_ffff);
    send_cmd(alee_pkg::CMD_APPEND, 0, 32'h8000_0000);
    send_cmd(alee_pkg::CMD_APPEND, 63, 32'h0000_0000);
    send_cmd(alee_pkg::CMD_APPEND, 0, 32'hffff_ffff);
    send_cmd(alee_pkg::CMD_INSERT, 2, 32'h1234_5678);
    send_cmd(alee_pkg::CMD_INSERT, 5, 32'hdead_beef);
    send_cmd(alee_pkg::CMD_UPDATE, 0, 32'h8000_0000);
    send_cmd(alee_pkg::CMD_UPDATE, 6, 32'h5555_5555);
    send_cmd(alee_pkg::CMD_UPDATE, 63, 32'haaaa_aaaa);
    send_cmd(alee_pkg::CMD_DELETE, 0, 32'h0);
    send_cmd(alee_pkg::CMD_DELETE, 4, 32'h0);
    send_cmd(alee_pkg::CMD_DELETE, 4, 32'h0);
    send_cmd(alee_pkg::CMD_APPEND, 0, 32'h7fff_ffff);
    send_cmd(alee_pkg::CMD_APPEND, 0, 32'h0000_0000);
    send_cmd(alee_pkg::CMD_DEDUPE, 0, 32'h0);
    send_cmd(CMD_UNUSED, 63, 32'hffff_ffff);
    send_cmd(alee_pkg::CMD_DUMP,   0, 32'h0);
    send_cmd(alee_pkg::CMD_CLEAR,  0, 32'h0);
    send_cmd(alee_pkg::CMD_DEDUPE, 0, 32'h0);
    send_cmd(alee_pkg::CMD_APPEND, 0, 32'hffff_ffff);
    send_cmd(alee_pkg::CMD_DELETE, 0, 32'h0);

    random_sent = 0;
    first = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      kind = first ? 0 : $urandom_range(0, 9);
      first = 1'b0;
      case (kind)
        0, 1: begin
          // grow to full, then knock on the full list
          while (len_est < CAPACITY) begin
            if ($urandom_range(0, 1) == 0)
              send_cmd(alee_pkg::CMD_APPEND, $urandom_range(0, 63), pick_value());
            else
              send_cmd(alee_pkg::CMD_INSERT, $urandom_range(0, len_est), pick_value());
          end
          send_cmd(alee_pkg::CMD_APPEND, $urandom_range(0, 63), pick_value());
          send_cmd(alee_pkg::CMD_INSERT, $urandom_range(0, CAPACITY), pick_value());
          if ($urandom_range(0, 1) == 0) send_cmd(alee_pkg::CMD_DEDUPE, 0, $urandom);
        end
        2, 3, 4, 5: begin
          n = $urandom_range(4, 10);
          repeat (n) begin
            op  = $urandom_range(0, 3);
            bad = ($urandom_range(0, 4) == 0);
            case (op)
              0: send_cmd(alee_pkg::CMD_APPEND, $urandom_range(0, 63), pick_value());
              1: begin
                if (len_est == 0 || bad)
                  send_cmd(alee_pkg::CMD_UPDATE, $urandom_range(len_est, 63), pick_value());
                else
                  send_cmd(alee_pkg::CMD_UPDATE, $urandom_range(0, len_est - 1), pick_value());
              end
              2: begin
                if (bad && len_est < 63)
                  send_cmd(alee_pkg::CMD_INSERT, $urandom_range(len_est + 1, 63), pick_value());
                else
                  send_cmd(alee_pkg::CMD_INSERT, $urandom_range(0, len_est), pick_value());
              end
              default: begin
                if (len_est == 0 || bad)
                  send_cmd(alee_pkg::CMD_DELETE, $urandom_range(len_est, 63), $urandom);
                else
                  send_cmd(alee_pkg::CMD_DELETE, $urandom_range(0, len_est - 1), $urandom);
              end
            endcase
          end
        end
        6: begin
          send_cmd(alee_pkg::CMD_DEDUPE, $urandom_range(0, 63), $urandom);
          send_cmd(alee_pkg::CMD_DUMP, $urandom_range(0, 63), $urandom);
        end
        7: begin
          send_cmd(alee_pkg::CMD_CLEAR, $urandom_range(0, 63), $urandom);
          n = $urandom_range(1, 4);
          repeat (n) send_cmd(alee_pkg::CMD_APPEND, $urandom_range(0, 63), pick_value());
        end
        default: begin
          // noise: any code, any position, any word
          n = $urandom_range(2, 5);
          repeat (n) send_cmd(CODE_W'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom);
        end
      endcase
    end

    cmd_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("array_list_edit_engine test passed");
    end else begin
      $display("array_list_edit_engine test failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/alee_pkg.sv
sv/alee_stream_if.sv
sv/alee_front.sv
sv/alee_back.sv
sv/array_list_edit_engine.sv
verif/array_list_edit_engine_checker.sv
verif/array_list_edit_engine_tb.sv
